// ===== src/assert_macros.svh =====
// assertion helpers for the dag edge store
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/desc_pkg.sv =====
// ----------------------------------------------------------------------------
// desc_pkg
// shared types, codes and helpers of the dag edge store with cycle check
// ----------------------------------------------------------------------------
package desc_pkg;

  localparam int NodeNum      = 64;
  localparam int IdW          = 6;
  localparam int MaxNodesDflt = 64;

  typedef enum logic [2:0] {
    MODE_ADD_NODE = 3'd0,
    MODE_DEL_NODE = 3'd1,
    MODE_ADD_EDGE = 3'd2,
    MODE_DEL_EDGE = 3'd3,
    MODE_QUERY    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MISSING = 3'd1,
    ST_SELF    = 3'd2,
    ST_EXISTS  = 3'd3,
    ST_CYCLE   = 3'd4,
    ST_NO_EDGE = 3'd5,
    ST_FULL    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_SEARCH,
    S_SWAIT,
    S_SWEEP_RD,
    S_SWEEP_WR,
    S_FIN
  } state_e;

  typedef logic [NodeNum-1:0] row_t;

  // index of the lowest set bit, zero when none
  function automatic logic [IdW-1:0] lowest_set(input row_t v);
    logic [IdW-1:0] idx;
    idx = '0;
    for (int i = NodeNum - 1; i >= 0; i--) begin
      if (v[i]) idx = IdW'(i);
    end
    return idx;
  endfunction

endpackage

// ===== src/dag_edge_store_cycle_check.sv =====
// ----------------------------------------------------------------------------
// dag_edge_store_cycle_check
// directed acyclic graph store: node slots, adjacency rows in a memory,
// edge adds refused when they would close a cycle, path queries
// ----------------------------------------------------------------------------
//  channel  dir  fields (lsb first)
//  s_axis   in   mode[2:0] source_node[8:3] target_node[14:9]
//  m_axis   out  status[2:0] allocated_node[8:3] path_found[9]
//
// one word at a time. node add, self loop, missing node and unused modes go straight
// to S_FIN; edge remove and the exists check read the source row in S_ROW. cycle check
// and path query expand one reachable node at a time (read in S_SEARCH, merged in
// S_SWAIT) over the single memory read port. node remove sweeps the rows.
// reset clears slot bits and control; rows are zeroed when a slot is given.
// a result waiting on m_axis holds the block in S_FIN and stalls s_axis.
`include "assert_macros.svh"

module dag_edge_store_cycle_check #(
  parameter int MAX_NODES = desc_pkg::MaxNodesDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // mode, source_node, target_node
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status, allocated_node, path_found
);

  localparam int SlotCount = (MAX_NODES < desc_pkg::NodeNum) ? MAX_NODES : desc_pkg::NodeNum;
  localparam int SlotW     = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  typedef logic [desc_pkg::IdW-1:0] id_t;

  desc_pkg::state_e state_q, state_d;
  desc_pkg::row_t   present_q, present_d;
  desc_pkg::row_t   visit_q, visit_d, pend_q, pend_d, row_q, row_d;
  desc_pkg::row_t   rd_q;
  desc_pkg::row_t   adj_mem [SlotCount];

  logic [2:0]       mode_q, mode_d;
  id_t              src_q, src_d, dst_q, dst_d, tgt_q, tgt_d;
  logic [SlotW-1:0] cnt_q, cnt_d;
  desc_pkg::status_e res_st_q, res_st_d;
  id_t              res_alloc_q, res_alloc_d;
  logic             res_found_q, res_found_d;
  logic             m_valid_q;
  logic [15:0]      m_data_q;

  logic             re_c, we_c;
  logic [SlotW-1:0] ra_c, wa_c;
  desc_pkg::row_t   wd_c, free_c, new_c;
  id_t              in_src, in_dst, pick_c;
  logic [2:0]       in_mode;
  logic             src_ok, dst_ok, fin_go;

  assign in_mode = s_axis_tdata[2:0];
  assign in_src  = s_axis_tdata[8:3];
  assign in_dst  = s_axis_tdata[14:9];
  assign src_ok  = (32'(in_src) < SlotCount) && present_q[in_src];
  assign dst_ok  = (32'(in_dst) < SlotCount) && present_q[in_dst];
  assign free_c  = ~present_q & ((SlotCount >= desc_pkg::NodeNum) ? '1 :
                   ((desc_pkg::row_t'(1) << SlotCount) - desc_pkg::row_t'(1)));
  assign pick_c  = desc_pkg::lowest_set(pend_q);
  assign new_c   = rd_q & present_q & ~visit_q;
  assign fin_go  = !m_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == desc_pkg::S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i) begin
    if (we_c) adj_mem[wa_c] <= wd_c;
    if (re_c) rd_q <= adj_mem[ra_c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= desc_pkg::S_IDLE;
      present_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      if (state_q == desc_pkg::S_FIN && fin_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    src_q       <= src_d;
    dst_q       <= dst_d;
    tgt_q       <= tgt_d;
    cnt_q       <= cnt_d;
    visit_q     <= visit_d;
    pend_q      <= pend_d;
    row_q       <= row_d;
    res_st_q    <= res_st_d;
    res_alloc_q <= res_alloc_d;
    res_found_q <= res_found_d;
    if (state_q == desc_pkg::S_FIN && fin_go) begin
      m_data_q <= {6'b0, res_found_q, res_alloc_q, res_st_q};
    end
  end

  always_comb begin
    state_d     = state_q;
    present_d   = present_q;
    mode_d      = mode_q;
    src_d       = src_q;
    dst_d       = dst_q;
    tgt_d       = tgt_q;
    cnt_d       = cnt_q;
    visit_d     = visit_q;
    pend_d      = pend_q;
    row_d       = row_q;
    res_st_d    = res_st_q;
    res_alloc_d = res_alloc_q;
    res_found_d = res_found_q;
    re_c        = 1'b0;
    we_c        = 1'b0;
    ra_c        = '0;
    wa_c        = '0;
    wd_c        = '0;
    unique case (state_q)
      desc_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d      = in_mode;
          src_d       = in_src;
          dst_d       = in_dst;
          res_st_d    = desc_pkg::ST_OK;
          res_alloc_d = '0;
          res_found_d = 1'b0;
          state_d     = desc_pkg::S_FIN;
          case (in_mode)
            desc_pkg::MODE_ADD_NODE: begin
              if (free_c == '0) begin
                res_st_d = desc_pkg::ST_FULL;
              end else begin
                res_alloc_d = desc_pkg::lowest_set(free_c);
                present_d[res_alloc_d] = 1'b1;
                we_c = 1'b1;
                wa_c = res_alloc_d[SlotW-1:0];
              end
            end
            desc_pkg::MODE_DEL_NODE: begin
              if (!src_ok) begin
                res_st_d = desc_pkg::ST_MISSING;
              end else begin
                present_d[in_src] = 1'b0;
                cnt_d   = '0;
                state_d = desc_pkg::S_SWEEP_RD;
              end
            end
            desc_pkg::MODE_ADD_EDGE, desc_pkg::MODE_DEL_EDGE, desc_pkg::MODE_QUERY: begin
              if (!src_ok || !dst_ok) begin
                res_st_d = desc_pkg::ST_MISSING;
              end else if (in_mode == desc_pkg::MODE_QUERY) begin
                visit_d = desc_pkg::row_t'(1) << in_src;
                pend_d  = desc_pkg::row_t'(1) << in_src;
                tgt_d   = in_dst;
                state_d = desc_pkg::S_SEARCH;
              end else if (in_mode == desc_pkg::MODE_ADD_EDGE && in_src == in_dst) begin
                res_st_d = desc_pkg::ST_SELF;
              end else begin
                re_c    = 1'b1;
                ra_c    = in_src[SlotW-1:0];
                state_d = desc_pkg::S_ROW;
              end
            end
            default: ;
          endcase
        end
      end
      desc_pkg::S_ROW: begin
        state_d = desc_pkg::S_FIN;
        if (mode_q == desc_pkg::MODE_DEL_EDGE) begin
          if (!rd_q[dst_q]) begin
            res_st_d = desc_pkg::ST_NO_EDGE;
          end else begin
            we_c = 1'b1;
            wa_c = src_q[SlotW-1:0];
            wd_c = rd_q & ~(desc_pkg::row_t'(1) << dst_q);
          end
        end else if (rd_q[dst_q]) begin
          res_st_d = desc_pkg::ST_EXISTS;
        end else begin
          // does the target already reach the source
          row_d   = rd_q;
          visit_d = desc_pkg::row_t'(1) << dst_q;
          pend_d  = desc_pkg::row_t'(1) << dst_q;
          tgt_d   = src_q;
          state_d = desc_pkg::S_SEARCH;
        end
      end
      desc_pkg::S_SEARCH: begin
        if (visit_q[tgt_q] || pend_q == '0) begin
          state_d = desc_pkg::S_FIN;
          if (mode_q == desc_pkg::MODE_QUERY) begin
            res_found_d = visit_q[tgt_q];
          end else if (visit_q[tgt_q]) begin
            res_st_d = desc_pkg::ST_CYCLE;
          end else begin
            we_c = 1'b1;
            wa_c = src_q[SlotW-1:0];
            wd_c = row_q | (desc_pkg::row_t'(1) << dst_q);
          end
        end else begin
          re_c = 1'b1;
          ra_c = pick_c[SlotW-1:0];
          pend_d[pick_c] = 1'b0;
          state_d = desc_pkg::S_SWAIT;
        end
      end
      desc_pkg::S_SWAIT: begin
        visit_d = visit_q | new_c;
        pend_d  = pend_q | new_c;
        state_d = desc_pkg::S_SEARCH;
      end
      desc_pkg::S_SWEEP_RD: begin
        re_c    = 1'b1;
        ra_c    = cnt_q;
        state_d = desc_pkg::S_SWEEP_WR;
      end
      desc_pkg::S_SWEEP_WR: begin
        // drop the removed node's column from every row
        we_c = 1'b1;
        wa_c = cnt_q;
        wd_c = rd_q & ~(desc_pkg::row_t'(1) << src_q);
        if (32'(cnt_q) == SlotCount - 1) begin
          state_d = desc_pkg::S_FIN;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = desc_pkg::S_SWEEP_RD;
        end
      end
      desc_pkg::S_FIN: begin
        if (fin_go) state_d = desc_pkg::S_IDLE;
      end
      default: state_d = desc_pkg::S_IDLE;
    endcase
  end

  `ASSERT_IMPLIES(a_found_ok, clk_i, rst_ni, m_valid_q && m_data_q[9], m_data_q[2:0] == desc_pkg::ST_OK, "path_found with bad status")
  `ASSERT_IMPLIES(a_alloc_ok, clk_i, rst_ni, m_valid_q && m_data_q[8:3] != '0, m_data_q[2:0] == desc_pkg::ST_OK, "allocated slot with bad status")
  `ASSERT_IMPLIES(a_no_rw_clash, clk_i, rst_ni, we_c && re_c, 1'b0, "memory read and write in one cycle")

endmodule

// ===== tb/dag_edge_store_cycle_check_tb.sv =====
// ----------------------------------------------------------------------------
// dag_edge_store_cycle_check_tb
// random and directed graph operations against a behavioral graph predictor,
// with sender gaps and receiver stalls in several phases
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dag_edge_store_cycle_check_tb;

  localparam int Slots = 64;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    desc_pkg::status_e status;
    logic [5:0]        alloc;
    logic              found;
  } graph_result_t;

  class graph_scoreboard;
    logic [63:0]   present;
    logic [63:0]   rows [64];
    graph_result_t pending [$];
    int            errors;

    function new();
      present = '0;
      errors  = 0;
      foreach (rows[i]) rows[i] = '0;
    endfunction

    function bit is_node(logic [5:0] id);
      return present[id];
    endfunction

    // frontier expansion from a over present nodes
    function bit reaches(logic [5:0] a, logic [5:0] b);
      logic [63:0] seen, front, nxt;
      seen = 64'd1 << a;
      front = seen;
      while (front != 0) begin
        nxt = '0;
        for (int n = 0; n < 64; n++) if (front[n]) nxt |= rows[n];
        nxt &= present & ~seen;
        seen |= nxt;
        front = nxt;
      end
      return seen[b];
    endfunction

    function void note_word(logic [2:0] op, logic [5:0] s, logic [5:0] t);
      graph_result_t r;
      r = '{desc_pkg::ST_OK, 6'd0, 1'b0};
      case (op)
        desc_pkg::MODE_ADD_NODE: begin
          if (&present) r.status = desc_pkg::ST_FULL;
          else begin
            for (int i = 63; i >= 0; i--) if (!present[i]) r.alloc = 6'(i);
            present[r.alloc] = 1'b1;
            rows[r.alloc] = '0;
          end
        end
        desc_pkg::MODE_DEL_NODE: begin
          if (!is_node(s)) r.status = desc_pkg::ST_MISSING;
          else begin
            for (int i = 0; i < 64; i++) rows[i][s] = 1'b0;
            rows[s] = '0;
            present[s] = 1'b0;
          end
        end
        desc_pkg::MODE_ADD_EDGE: begin
          if (!is_node(s) || !is_node(t)) r.status = desc_pkg::ST_MISSING;
          else if (s == t) r.status = desc_pkg::ST_SELF;
          else if (rows[s][t]) r.status = desc_pkg::ST_EXISTS;
          else if (reaches(t, s)) r.status = desc_pkg::ST_CYCLE;
          else rows[s][t] = 1'b1;
        end
        desc_pkg::MODE_DEL_EDGE: begin
          if (!is_node(s) || !is_node(t)) r.status = desc_pkg::ST_MISSING;
          else if (!rows[s][t]) r.status = desc_pkg::ST_NO_EDGE;
          else rows[s][t] = 1'b0;
        end
        desc_pkg::MODE_QUERY: begin
          if (!is_node(s) || !is_node(t)) r.status = desc_pkg::ST_MISSING;
          else r.found = reaches(s, t);
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    task check_word(logic [15:0] d);
      graph_result_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", d));
        return;
      end
      e = pending.pop_front();
      if (d[2:0] != e.status)
        report_mismatch($sformatf("status %0d, want %0d", d[2:0], e.status));
      if (d[8:3] != e.alloc)
        report_mismatch($sformatf("allocated_node %0d, want %0d", d[8:3], e.alloc));
      if (d[9] != e.found)
        report_mismatch($sformatf("path_found %0d, want %0d", d[9], e.found));
      if (d[15:10] != 0)
        report_mismatch($sformatf("pad bits set %h", d));
    endtask

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // mode, source_node, target_node
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // status, allocated_node, path_found

  graph_scoreboard graph_sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_cnt = 0;
  longint cycles = 0;

  always #5 clk_i = ~clk_i;

  dag_edge_store_cycle_check u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // long receiver hold-off, counted in cycles
  always @(posedge clk_i) begin
    if (hold_cnt < hold_len) hold_cnt <= hold_cnt + 1;
  end

  // receiver: random stalls, plus the long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) graph_sb.check_word(m_axis_tdata);
      if (hold_cnt < hold_len) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(logic [2:0] op, logic [5:0] s, logic [5:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, t, s, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    graph_sb.note_word(op, s, t);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (graph_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // mostly present nodes, sometimes any slot
  function automatic logic [5:0] pick_node();
    logic [5:0] id;
    if ($urandom_range(9) < 8 && graph_sb.present != 0) begin
      do id = 6'($urandom_range(Slots - 1)); while (!graph_sb.present[id]);
      return id;
    end
    return 6'($urandom_range(63));
  endfunction

  task automatic random_words(int n);
    int r;
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 14) op = desc_pkg::MODE_ADD_NODE;
      else if (r < 20) op = desc_pkg::MODE_DEL_NODE;
      else if (r < 55) op = desc_pkg::MODE_ADD_EDGE;
      else if (r < 65) op = desc_pkg::MODE_DEL_EDGE;
      else if (r < 97) op = desc_pkg::MODE_QUERY;
      else op = 3'($urandom_range(5, 7));
      send_word(op, pick_node(), pick_node());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty graph cases, chain, cycle, self loop, removals
    send_word(desc_pkg::MODE_DEL_NODE, 6'd0, 6'd0);
    send_word(desc_pkg::MODE_QUERY, 6'd63, 6'd0);
    send_word(desc_pkg::MODE_ADD_NODE, 6'd63, 6'd63);
    send_word(desc_pkg::MODE_ADD_NODE, 6'd0, 6'd0);
    send_word(desc_pkg::MODE_ADD_NODE, 6'd0, 6'd0);
    send_word(desc_pkg::MODE_ADD_EDGE, 6'd0, 6'd1);
    send_word(desc_pkg::MODE_ADD_EDGE, 6'd1, 6'd2);
    send_word(desc_pkg::MODE_ADD_EDGE, 6'd0, 6'd1);
    send_word(desc_pkg::MODE_ADD_EDGE, 6'd2, 6'd0);
    send_word(desc_pkg::MODE_ADD_EDGE, 6'd1, 6'd1);
    send_word(desc_pkg::MODE_ADD_EDGE, 6'd0, 6'd63);
    send_word(desc_pkg::MODE_QUERY, 6'd0, 6'd2);
    send_word(desc_pkg::MODE_QUERY, 6'd2, 6'd0);
    send_word(desc_pkg::MODE_QUERY, 6'd1, 6'd1);
    send_word(desc_pkg::MODE_DEL_EDGE, 6'd2, 6'd0);
    send_word(desc_pkg::MODE_DEL_EDGE, 6'd0, 6'd1);
    send_word(desc_pkg::MODE_DEL_EDGE, 6'd63, 6'd1);
    send_word(3'd5, 6'd63, 6'd63);
    send_word(3'd7, 6'd0, 6'd0);
    send_word(desc_pkg::MODE_DEL_NODE, 6'd1, 6'd0);
    send_word(desc_pkg::MODE_QUERY, 6'd0, 6'd2);
    send_word(desc_pkg::MODE_ADD_NODE, 6'd0, 6'd0);
    // fill every slot, then one more for the full status
    while (graph_sb.present != '1) send_word(desc_pkg::MODE_ADD_NODE, 6'd0, 6'd0);
    send_word(desc_pkg::MODE_ADD_NODE, 6'd0, 6'd0);
    send_word(desc_pkg::MODE_DEL_NODE, 6'd63, 6'd0);
    for (int i = 0; i < 62; i++) send_word(desc_pkg::MODE_ADD_EDGE, 6'(i), 6'(i + 1));
    send_word(desc_pkg::MODE_QUERY, 6'd0, 6'd62);
    send_word(desc_pkg::MODE_ADD_EDGE, 6'd62, 6'd0);
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  random_words(250);
    // receiver holds off while the sender keeps offering
    hold_len = 400;
    random_words(20);
    drain();
    send_idle_pct = 73; recv_stall_pct = 0;  random_words(250);
    send_idle_pct = 0;  recv_stall_pct = 73; random_words(250);
    send_idle_pct = 14; recv_stall_pct = 14; random_words(250);
    drain();
    // clear out and rebuild small graphs
    for (int i = 0; i < 64; i++) send_word(desc_pkg::MODE_DEL_NODE, 6'(i), 6'd0);
    send_idle_pct = 0;  recv_stall_pct = 0;  random_words(100);
    drain();
    repeat (300) @(posedge clk_i);

    if (graph_sb.errors == 0 && graph_sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
